@@ hw/rtl/handle_table_allocator_top_assert.svh @@
// Assertion macros for the handle table allocator.
// Included by the modules that check their own control and datapath logic.
`ifndef HANDLE_TABLE_ALLOCATOR_TOP_ASSERT_SVH
`define HANDLE_TABLE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked after reset has been released.
`define HTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("handle table assertion failed");
// Checked on every edge, including during reset.
`define HTA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("handle table assertion failed");
`else
`define HTA_ASSERT(lbl, prop)
`define HTA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hw/rtl/hta_pkg.sv @@
// Shared sizes, codes and controller/datapath interface types for the handle table.
// No dependencies; used by hta_ctrl, hta_dp and the top level.
package hta_pkg;

  localparam int SLOTS      = 256;
  localparam int VALUE_BITS = 64;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int HCMP_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;   // capture the input item
    logic rd;     // read the slot and free stack memories
    logic exec;   // update state, load the result register
  } hta_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } hta_sts_t;

endpackage

@@ hw/rtl/hta_ctrl.sv @@
// Sequencer for the handle table: capture, memory read, execute.
// Depends on hta_pkg and the assertion header.
`include "handle_table_allocator_top_assert.svh"

module hta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hta_pkg::hta_sts_t sts,
  output hta_pkg::hta_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        // hold here while an earlier result still sits in the output register
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HTA_ASSERT(a_accept_to_rd, (in_valid && !in_stall) |=> (state_r == S_RD))
  `HTA_ASSERT(a_rd_to_ex, (state_r == S_RD) |=> (state_r == S_EX))
  `HTA_ASSERT(a_exec_needs_room, cmd.exec |-> sts.out_free)

endmodule

@@ hw/rtl/hta_dp.sv @@
// Datapath for the handle table: slot and free stack memories, live bits,
// counters and the result register. Depends on hta_pkg and the assertion header.
`include "handle_table_allocator_top_assert.svh"

module hta_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_opcode,
  input  logic [63:0]           in_value,
  input  logic [7:0]            in_handle,
  input  hta_pkg::hta_cmd_t     cmd,
  output hta_pkg::hta_sts_t     sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_handle_out,
  output logic [63:0]           out_value_out,
  output logic [1:0]            out_status,
  output logic                  out_released
);

  localparam int SW = hta_pkg::SLOT_W;
  localparam int CW = hta_pkg::CNT_W;
  localparam int HW = hta_pkg::HCMP_W;
  localparam int VW = hta_pkg::VALUE_BITS;

  logic [VW-1:0]          slot_mem [hta_pkg::SLOTS];
  logic [SW-1:0]          stack_mem [hta_pkg::SLOTS];
  logic [hta_pkg::SLOTS-1:0] live_r;

  logic [1:0]    op_r;
  logic [VW-1:0] val_r;
  logic [7:0]    h_r;
  logic [VW-1:0] slot_rd_r;
  logic [SW-1:0] stack_rd_r;
  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] hw_r, hw_nxt;

  logic          ov_r;
  logic [7:0]    oh_r;
  logic [63:0]   ovl_r;
  logic [1:0]    ost_r;
  logic          orel_r;

  logic [SW-1:0] h_idx;
  logic          in_range, live_h;
  logic          st_from_stack, st_fresh, st_ok, fr_ok, get_ok;
  logic [SW-1:0] st_idx;
  logic [7:0]    res_h;
  logic [63:0]   res_v;
  logic [1:0]    res_st;
  logic          res_rel;

  assign h_idx    = SW'(h_r);
  assign in_range = HW'(h_r) < HW'(hw_r);
  assign live_h   = live_r[h_idx];

  assign st_from_stack = (fc_r != '0);
  assign st_fresh      = !st_from_stack && (hw_r < CW'(hta_pkg::SLOTS));
  assign st_ok         = (op_r == hta_pkg::OP_STORE) && (st_from_stack || st_fresh);
  assign st_idx        = st_from_stack ? stack_rd_r : SW'(hw_r);
  assign get_ok        = (op_r == hta_pkg::OP_GET) && in_range && live_h;
  assign fr_ok         = (op_r == hta_pkg::OP_FREE) && in_range && live_h &&
                         (fc_r < CW'(hta_pkg::SLOTS));

  assign sts.out_free = !ov_r || !out_stall;

  always_comb begin
    res_h   = h_r;
    res_v   = '0;
    res_st  = hta_pkg::ST_OK;
    res_rel = 1'b0;
    fc_nxt  = fc_r;
    hw_nxt  = hw_r;
    case (op_r)
      hta_pkg::OP_STORE: begin
        if (st_ok) begin
          res_h = 8'(st_idx);
          if (st_from_stack) begin
            fc_nxt = CW'(fc_r - 1'b1);
          end else begin
            hw_nxt = CW'(hw_r + 1'b1);
          end
        end else begin
          res_st = hta_pkg::ST_FULL;
        end
      end
      hta_pkg::OP_GET: begin
        if (get_ok) begin
          res_v = 64'(slot_rd_r);
        end else begin
          res_st = hta_pkg::ST_BAD;
        end
      end
      hta_pkg::OP_FREE: begin
        if (fr_ok) begin
          res_v   = 64'(slot_rd_r);
          res_rel = 1'b1;
          fc_nxt  = CW'(fc_r + 1'b1);
        end else begin
          res_st = hta_pkg::ST_BAD;
        end
      end
      default: begin
        fc_nxt = '0;
        hw_nxt = '0;
      end
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= VW'(in_value);
      h_r   <= in_handle;
    end
  end

  // slot values: read in the read step, written by a successful store
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      slot_rd_r <= slot_mem[h_idx];
    end
    if (cmd.exec && st_ok) begin
      slot_mem[st_idx] <= val_r;
    end
  end

  // free stack: top entry read in the read step, pushed by a successful free
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      stack_rd_r <= stack_mem[SW'(fc_r - 1'b1)];
    end
    if (cmd.exec && fr_ok) begin
      stack_mem[SW'(fc_r)] <= h_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      fc_r   <= '0;
      hw_r   <= '0;
    end else if (cmd.exec) begin
      fc_r <= fc_nxt;
      hw_r <= hw_nxt;
      if (op_r == hta_pkg::OP_CLEAR) begin
        live_r <= '0;
      end else if (st_ok) begin
        live_r[st_idx] <= 1'b1;
      end else if (fr_ok) begin
        live_r[h_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.exec) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      oh_r   <= res_h;
      ovl_r  <= res_v;
      ost_r  <= res_st;
      orel_r <= res_rel;
    end
  end

  assign out_valid      = ov_r;
  assign out_handle_out = oh_r;
  assign out_value_out  = ovl_r;
  assign out_status     = ost_r;
  assign out_released   = orel_r;

  `HTA_ASSERT(a_stack_below_hw, fc_r <= hw_r)
  `HTA_ASSERT(a_exec_loads_out, cmd.exec |=> out_valid)
  `HTA_ASSERT(a_no_overwrite, cmd.exec |-> !(ov_r && out_stall))

endmodule

@@ hw/rtl/handle_table_allocator_top.sv @@
// Top level of the handle table allocator: controller plus datapath.
// Depends on hta_pkg, hta_ctrl and hta_dp.
//
//   channel | direction | ports                                         | handshake
//   in      | input     | in_opcode, in_value, in_handle                 | in_valid / in_stall
//   out     | output    | out_handle_out, out_value_out, out_status,     | out_valid / out_stall
//           |           | out_released                                   |
//
// Each item goes through capture, one registered read of the slot and
// free stack memories, then execute, which loads the result register.
// A new item is accepted the cycle after execute, not while an earlier item is in progress.
// Execute waits while the result register holds an untaken result under out_stall.
// Synchronous active-low reset empties the table at once (live bits are flops);
// no clearing pass is needed, and a clear operation goes through the same steps as any other item.

module handle_table_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_value,
  input  logic [7:0]  in_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_handle_out,
  output logic [63:0] out_value_out,
  output logic [1:0]  out_status,
  output logic        out_released
);

  hta_pkg::hta_cmd_t cmd;
  hta_pkg::hta_sts_t sts;

  hta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hta_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .in_handle      (in_handle),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_handle_out (out_handle_out),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_released   (out_released)
  );

endmodule
